[rtl/core/ptwa_pkg.sv]
// shared types, codes and constants of the presence table with aging
`default_nettype none
package ptwa_pkg;

	// widths fixed by the item format
	localparam int OP_W      = 2;
	localparam int ID_W      = 64;
	localparam int NICK_W    = 64;
	localparam int ROOM_W    = 8;
	localparam int KIND_W    = 3;
	localparam int SLOT_W    = 4;
	localparam int TICK_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// parameter defaults
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int NICK_BYTES_DEF  = 8;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// input operations
	localparam logic [OP_W-1:0] OP_ANNOUNCE = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_UPDATED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OFFLINE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MISS      = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd6;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP   = 1'd1;
	localparam logic [CFG_W-1:0]     TIMEOUT_RST = 16'd25;
	localparam logic [CFG_W-1:0]     SWEEP_RST   = 16'd25;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   out_id;
		logic [NICK_W-1:0] out_nick;
		logic [ROOM_W-1:0] out_room;
		logic              last;
	} rsp_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

[rtl/core/ptwa_ifs.sv]
// item channel interfaces of the presence table
`default_nettype none
interface ptwa_req_if;
	logic                          valid;
	logic                          ready;
	logic [ptwa_pkg::OP_W-1:0]     op;
	logic [ptwa_pkg::ID_W-1:0]     peer_id;
	logic [ptwa_pkg::NICK_W-1:0]   peer_nick;
	logic [ptwa_pkg::ROOM_W-1:0]   peer_room;

	modport source (output valid, op, peer_id, peer_nick, peer_room, input ready);
	modport sink   (input valid, op, peer_id, peer_nick, peer_room, output ready);
endinterface

interface ptwa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptwa_pkg::KIND_W-1:0]   kind;
	logic [ptwa_pkg::SLOT_W-1:0]   slot;
	logic [ptwa_pkg::ID_W-1:0]     out_id;
	logic [ptwa_pkg::NICK_W-1:0]   out_nick;
	logic [ptwa_pkg::ROOM_W-1:0]   out_room;
	logic                          last;

	modport source (output valid, kind, slot, out_id, out_nick, out_room, last, input ready);
	modport sink   (input valid, kind, slot, out_id, out_nick, out_room, last, output ready);
endinterface
`default_nettype wire

[rtl/core/ptwa_front.sv]
// front end: takes items, trims the nickname, drops unused ops, fills the queue
`default_nettype none
module ptwa_front #(
	parameter int NICK_BYTES = ptwa_pkg::NICK_BYTES_DEF,
	parameter int ENTRY_W    = ptwa_pkg::OP_W + ptwa_pkg::ID_W + 8 * NICK_BYTES
		+ ptwa_pkg::ROOM_W
) (
	ptwa_req_if.sink           req,
	input  ptwa_pkg::q_stat_t  q_stat,
	output logic               push,
	output logic [ENTRY_W-1:0] push_data
);
	import ptwa_pkg::*;

	localparam int NW = 8 * NICK_BYTES;

	logic [NW-1:0] nick_c;

	// bounded string copy: everything from the first zero byte on is cleared
	always_comb begin
		logic       live;
		logic [7:0] bval;
		live   = 1'b1;
		nick_c = '0;
		for (int b = 0; b < NICK_BYTES; b++) begin
			bval = req.peer_nick[8*b +: 8];
			if (bval == 8'd0) live = 1'b0;
			if (live) nick_c[8*b +: 8] = bval;
		end
	end

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full && (req.op != OP_NONE);
	assign push_data = {req.op, req.peer_id, nick_c, req.peer_room};

endmodule
`default_nettype wire

[rtl/core/ptwa_queue.sv]
// short queue between front and back
`default_nettype none
module ptwa_queue #(
	parameter int W = 138
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      push_data,
	input  logic              pop,
	output logic [W-1:0]      pop_data,
	output ptwa_pkg::q_stat_t stat
);
	import ptwa_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  data_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= nxt(wptr_q);
			if (pop)  rptr_q <= nxt(rptr_q);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wptr_q] <= push_data;
	end

	assign pop_data   = data_q[rptr_q];
	assign stat.full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule
`default_nettype wire

[rtl/core/ptwa_back.sv]
// back end: table memory, serial scan engine, aging and result register
`default_nettype none
module ptwa_back #(
	parameter int TABLE_DEPTH = ptwa_pkg::TABLE_DEPTH_DEF,
	parameter int NICK_BYTES  = ptwa_pkg::NICK_BYTES_DEF,
	parameter int ENTRY_W     = ptwa_pkg::OP_W + ptwa_pkg::ID_W + 8 * NICK_BYTES
		+ ptwa_pkg::ROOM_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptwa_pkg::q_stat_t              q_stat,
	input  logic [ENTRY_W-1:0]             q_data,
	output logic                           q_pop,
	input  logic                           cfg_wr_en,
	input  logic [ptwa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptwa_pkg::CFG_W-1:0]     cfg_data,
	ptwa_rsp_if.source                     rsp
);
	import ptwa_pkg::*;

	localparam int NW = 8 * NICK_BYTES;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [NW-1:0]     nick;
		logic [ROOM_W-1:0] room;
		logic [TICK_W-1:0] heard;
	} entry_t;

	entry_t mem [TABLE_DEPTH];

	logic [1:0]             state_q;
	logic [OP_W-1:0]        cmd_op_q;
	logic [ID_W-1:0]        cmd_id_q;
	logic [NW-1:0]          cmd_nick_q;
	logic [ROOM_W-1:0]      cmd_room_q;
	logic [UW-1:0]          idx_q;
	logic [UW-1:0]          used_q;
	logic [IW-1:0]          ev_idx_s1;
	logic                   ev_vld_s1;
	entry_t                 rd_s1;
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [TABLE_DEPTH-1:0] online_q;
	logic [TICK_W-1:0]      now_q;
	logic [CFG_W-1:0]       phase_q;
	logic [CFG_W-1:0]       timeout_q;
	logic [CFG_W-1:0]       interval_q;
	logic                   ovld_q;
	rsp_t                   out_q;

	logic [OP_W-1:0]   in_op;
	logic [ID_W-1:0]   in_id;
	logic [NW-1:0]     in_nick;
	logic [ROOM_W-1:0] in_room;
	logic              can_emit, emit;
	rsp_t              emit_rsp;
	logic              hit_now, expire_now, stall, last_ev, issue, scan_done, sweep;
	logic [TICK_W-1:0] age;
	logic              fin_go, mem_we;
	logic [IW-1:0]     mem_waddr;
	logic              do_insert;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
		logic [IW+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, i};
		return w[SLOT_W-1:0];
	endfunction

	assign {in_op, in_id, in_nick, in_room} = q_data;

	assign can_emit   = !ovld_q || rsp.ready;
	assign hit_now    = ev_vld_s1 && (cmd_op_q != OP_TICK) && (rd_s1.id == cmd_id_q);
	assign age        = now_q - rd_s1.heard;
	assign expire_now = ev_vld_s1 && (cmd_op_q == OP_TICK) && online_q[ev_idx_s1]
		&& (age >= TICK_W'(timeout_q));
	assign stall      = expire_now && !can_emit;
	assign last_ev    = ev_vld_s1 && (UW'(ev_idx_s1) + UW'(1) == used_q);
	assign issue      = (state_q == ST_SCAN) && !stall && !hit_now && (idx_q < used_q);
	assign scan_done  = (state_q == ST_SCAN) && !stall && (hit_now || last_ev);
	assign sweep      = (phase_q >= interval_q);
	assign q_pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign fin_go     = (state_q == ST_FIN) && can_emit;
	assign do_insert  = !hit_q && (used_q < UW'(TABLE_DEPTH));
	assign mem_we     = fin_go && (cmd_op_q == OP_ANNOUNCE) && (hit_q || do_insert);
	assign mem_waddr  = hit_q ? hit_idx_q : used_q[IW-1:0];

	// result selection
	always_comb begin
		emit     = 1'b0;
		emit_rsp = '0;
		unique case (state_q)
			ST_SCAN: begin
				if (expire_now && can_emit) begin
					emit              = 1'b1;
					emit_rsp.kind     = KIND_OFFLINE;
					emit_rsp.slot     = to_slot(ev_idx_s1);
					emit_rsp.out_id   = rd_s1.id;
					emit_rsp.out_nick = NICK_W'(rd_s1.nick);
					emit_rsp.out_room = rd_s1.room;
				end
			end
			ST_FIN: begin
				emit          = can_emit;
				emit_rsp.last = 1'b1;
				unique case (cmd_op_q)
					OP_ANNOUNCE: begin
						emit_rsp.out_id   = cmd_id_q;
						emit_rsp.out_nick = NICK_W'(cmd_nick_q);
						emit_rsp.out_room = cmd_room_q;
						if (hit_q) begin
							emit_rsp.kind = KIND_UPDATED;
							emit_rsp.slot = to_slot(hit_idx_q);
						end else if (do_insert) begin
							emit_rsp.kind = KIND_INSERTED;
							emit_rsp.slot = to_slot(used_q[IW-1:0]);
						end else begin
							emit_rsp.kind = KIND_DROPPED;
						end
					end
					OP_LOOKUP: begin
						emit_rsp.out_id = cmd_id_q;
						if (hit_q) begin
							emit_rsp.kind     = KIND_FOUND;
							emit_rsp.slot     = to_slot(hit_idx_q);
							emit_rsp.out_nick = NICK_W'(rd_s1.nick);
							emit_rsp.out_room = rd_s1.room;
						end else begin
							emit_rsp.kind = KIND_MISS;
						end
					end
					OP_TICK: emit_rsp.kind = KIND_TICK_DONE;
					default: emit = 1'b0;
				endcase
			end
			default: emit = 1'b0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			used_q    <= '0;
			ev_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			online_q  <= '0;
			now_q     <= '0;
			phase_q   <= '0;
			ovld_q    <= 1'b0;
		end else begin
			if (emit)           ovld_q <= 1'b1;
			else if (rsp.ready) ovld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						hit_q     <= 1'b0;
						idx_q     <= '0;
						ev_vld_s1 <= 1'b0;
						if (in_op == OP_TICK && sweep) phase_q <= '0;
						if ((in_op == OP_TICK && !sweep) || used_q == '0) state_q <= ST_FIN;
						else state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!stall) ev_vld_s1 <= issue;
					if (issue) idx_q <= idx_q + UW'(1);
					if (hit_now) hit_q <= 1'b1;
					if (expire_now && can_emit) online_q[ev_idx_s1] <= 1'b0;
					if (scan_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (mem_we) online_q[mem_waddr] <= 1'b1;
						if (cmd_op_q == OP_ANNOUNCE && do_insert) used_q <= used_q + UW'(1);
						if (cmd_op_q == OP_TICK) begin
							now_q   <= now_q + TICK_W'(1);
							phase_q <= phase_q + CFG_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			interval_q <= SWEEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_q  <= cfg_data;
				CFG_SWEEP:   interval_q <= cfg_data;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_op_q   <= in_op;
			cmd_id_q   <= in_id;
			cmd_nick_q <= in_nick;
			cmd_room_q <= in_room;
		end
		if (issue)   ev_idx_s1 <= idx_q[IW-1:0];
		if (hit_now) hit_idx_q <= ev_idx_s1;
		if (emit)    out_q     <= emit_rsp;
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= '{id: cmd_id_q, nick: cmd_nick_q,
			room: cmd_room_q, heard: now_q};
	end

	always_ff @(posedge clk) begin
		if (issue) rd_s1 <= mem[idx_q[IW-1:0]];
	end

	assign rsp.valid    = ovld_q;
	assign rsp.kind     = out_q.kind;
	assign rsp.slot     = out_q.slot;
	assign rsp.out_id   = out_q.out_id;
	assign rsp.out_nick = out_q.out_nick;
	assign rsp.out_room = out_q.out_room;
	assign rsp.last     = out_q.last;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= used_q)
		else $error("scan index past fill count");

	a_eval_used: assert property (@(posedge clk) disable iff (!arst_n)
		ev_vld_s1 |-> UW'(ev_idx_s1) < used_q)
		else $error("evaluating an unused entry");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && cmd_op_q == OP_ANNOUNCE && do_insert)
		|=> used_q == $past(used_q) + UW'(1))
		else $error("insert did not grow the table");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && cmd_op_q == OP_TICK) |=> now_q == $past(now_q) + TICK_W'(1))
		else $error("tick did not advance time");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> state_q == ST_IDLE && !ev_vld_s1)
		else $error("finish did not return to idle");

endmodule
`default_nettype wire

[rtl/core/presence_table_with_aging_core.sv]
// top level of the presence table with aging
// Presence table: keeps up to TABLE_DEPTH peers keyed by a 64-bit id, each with
// a nickname (trimmed at its first zero byte, NICK_BYTES kept), a room and the
// tick it was last heard. An announce item refreshes or appends an entry and
// gives one result (updated, inserted or full dropped); a lookup item gives
// found or miss; a tick item gives one went-offline result per expired entry in
// slot order when a sweep is due, then tick done, the final result flagged by
// last. Unused op codes are swallowed without a result. The front accepts and
// queues items while the back works, and a result register lets the next item
// enter while a result waits. The back scans the table through a single read
// port, one entry a cycle unless a went-offline result waits on a stalled
// result side; a lookup or announce ends the scan at its first hit, and an
// empty table or a tick without sweep skips the scan. No clearing pass after
// reset: only entries below the fill count are ever read.
`default_nettype none
module presence_table_with_aging_core #(
	parameter int TABLE_DEPTH = ptwa_pkg::TABLE_DEPTH_DEF,
	parameter int NICK_BYTES  = ptwa_pkg::NICK_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes, only while idle
	input  logic                           cfg_wr_en,
	input  logic [ptwa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptwa_pkg::CFG_W-1:0]     cfg_data,
	// item channels
	ptwa_req_if.sink                       req,
	ptwa_rsp_if.source                     rsp
);
	import ptwa_pkg::*;

	// queued item: op, id, trimmed nickname, room
	localparam int ENTRY_W = OP_W + ID_W + 8 * NICK_BYTES + ROOM_W;

	logic               push, pop;
	logic [ENTRY_W-1:0] push_data, pop_data;
	q_stat_t            q_stat;

	// front: trims the nickname and filters unused ops
	ptwa_front #(
		.NICK_BYTES (NICK_BYTES),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.req       (req),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the accept side from the scan engine
	ptwa_queue #(
		.W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// back: table, scan, aging sweep and result register
	ptwa_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NICK_BYTES  (NICK_BYTES),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_data    (pop_data),
		.q_pop     (pop),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

[tb/presence_table_with_aging_core_test.sv]
// testbench of the presence table with aging: directed table, random phases, scoreboard
`default_nettype none
module presence_table_with_aging_core_test;
	import ptwa_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int SETTLE_CYC  = 40;        // well beyond a full-table scan
	localparam int PHASE_ITEMS = 60;
	localparam int PHASES      = 8;

	// one row of stimulus; typed rows carry their result written out by hand
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [NICK_W-1:0] nick;
		logic [ROOM_W-1:0] room;
		bit                typed;
		int                n_typed;
		rsp_t              want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ptwa_req_if req_ch ();
	ptwa_rsp_if rsp_ch ();

	presence_table_with_aging_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the peer table, the tick counter and the registers
	logic [ID_W-1:0]   tbl_id     [DEPTH];
	logic [NICK_W-1:0] tbl_nick   [DEPTH];
	logic [ROOM_W-1:0] tbl_room   [DEPTH];
	logic [TICK_W-1:0] tbl_heard  [DEPTH];
	bit                tbl_online [DEPTH];
	int                tbl_used     = 0;
	logic [TICK_W-1:0] now_tick     = '0;
	logic [CFG_W-1:0]  sweep_phase  = '0;
	logic [CFG_W-1:0]  cur_timeout  = TIMEOUT_RST;
	logic [CFG_W-1:0]  cur_interval = SWEEP_RST;

	rsp_t      pending_results[$];
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	bit        no_idle = 1'b0;
	int        stall_left = 0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			tbl_online[i] = 1'b0;
		end
	end

	function automatic rsp_t mk_rsp(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
		logic [ID_W-1:0] id, logic [NICK_W-1:0] nick, logic [ROOM_W-1:0] room, logic last);
		rsp_t r;
		r.kind     = kind;
		r.slot     = slot;
		r.out_id   = id;
		r.out_nick = nick;
		r.out_room = room;
		r.last     = last;
		return r;
	endfunction

	// appends one expected result behind the older ones
	function automatic void expect_result(rsp_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// bounded string copy: bytes after the first zero byte are cleared
	function automatic logic [NICK_W-1:0] trim_nick(logic [NICK_W-1:0] v);
		logic [NICK_W-1:0] r;
		r = '0;
		for (int b = 0; b < NICK_BYTES_DEF; b++) begin
			if (v[8*b +: 8] == 8'h00) break;
			r[8*b +: 8] = v[8*b +: 8];
		end
		return r;
	endfunction

	// updates the shadow table for one accepted item and, when keep is set, queues its results
	function automatic void presence_predict(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
		logic [NICK_W-1:0] nick_raw, logic [ROOM_W-1:0] room, bit keep);
		logic [NICK_W-1:0] nick;
		logic [TICK_W-1:0] age;
		int                hit;
		nick = trim_nick(nick_raw);
		hit  = -1;
		for (int i = 0; i < tbl_used; i++) begin
			if (hit < 0 && tbl_id[i] == id) hit = i;
		end
		case (op)
			OP_ANNOUNCE: begin
				if (hit >= 0) begin
					tbl_nick[hit]   = nick;
					tbl_room[hit]   = room;
					tbl_heard[hit]  = now_tick;
					tbl_online[hit] = 1'b1;
					if (keep) expect_result(
						mk_rsp(KIND_UPDATED, SLOT_W'(hit), id, nick, room, 1'b1));
				end else if (tbl_used < DEPTH) begin
					tbl_id[tbl_used]     = id;
					tbl_nick[tbl_used]   = nick;
					tbl_room[tbl_used]   = room;
					tbl_heard[tbl_used]  = now_tick;
					tbl_online[tbl_used] = 1'b1;
					if (keep) expect_result(
						mk_rsp(KIND_INSERTED, SLOT_W'(tbl_used), id, nick, room, 1'b1));
					tbl_used++;
				end else if (keep) begin
					expect_result(mk_rsp(KIND_DROPPED, '0, id, nick, room, 1'b1));
				end
			end
			OP_LOOKUP: begin
				if (!keep) begin
				end else if (hit >= 0) begin
					expect_result(mk_rsp(KIND_FOUND, SLOT_W'(hit), id,
						tbl_nick[hit], tbl_room[hit], 1'b1));
				end else begin
					expect_result(mk_rsp(KIND_MISS, '0, id, '0, '0, 1'b1));
				end
			end
			OP_TICK: begin
				// aging sweep first, ages taken modulo 2^32
				if (sweep_phase >= cur_interval) begin
					sweep_phase = '0;
					for (int i = 0; i < tbl_used; i++) begin
						age = now_tick - tbl_heard[i];
						if (tbl_online[i] && age >= TICK_W'(cur_timeout)) begin
							tbl_online[i] = 1'b0;
							if (keep) expect_result(mk_rsp(KIND_OFFLINE,
								SLOT_W'(i), tbl_id[i], tbl_nick[i], tbl_room[i], 1'b0));
						end
					end
				end
				now_tick    = now_tick + 1'b1;
				sweep_phase = sweep_phase + 1'b1;
				if (keep) expect_result(mk_rsp(KIND_TICK_DONE, '0, '0, '0, '0, 1'b1));
			end
			default: begin
				// unused op code is swallowed
			end
		endcase
	endfunction

	function automatic logic [NICK_W-1:0] random_nick();
		logic [NICK_W-1:0] v;
		int                r;
		int                p;
		v = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		p = $urandom_range(0, 7);
		if (r < 3) begin
			v[8*p +: 8] = 8'h00;         // zero byte at a random position
		end else if (r < 5) begin
			v = v >> (8 * (p + 1));      // short nickname, high bytes empty
		end
		return v;
	endfunction

	function automatic void add_row(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
		logic [NICK_W-1:0] nick, logic [ROOM_W-1:0] room,
		bit typed = 1'b0, int n_typed = 0, rsp_t want = '0);
		stim_row_t row;
		row.op      = op;
		row.id      = id;
		row.nick    = nick;
		row.room    = room;
		row.typed   = typed;
		row.n_typed = n_typed;
		row.want    = want;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// sender gap: mostly none, some short, a few long
	function automatic int sender_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// present one item, hold it until accepted, then predict its results
	task automatic send_item(input stim_row_t row);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.op        <= row.op;
		req_ch.peer_id   <= row.id;
		req_ch.peer_nick <= row.nick;
		req_ch.peer_room <= row.room;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		presence_predict(row.op, row.id, row.nick, row.room, !row.typed);
		if (row.typed && row.n_typed > 0) expect_result(row.want);
		gap = sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected result is in, then let the block settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// both registers, back to back, only while idle
	task automatic write_config(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] ivl);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= tmo;
		@(posedge clk);
		cfg_index <= CFG_SWEEP;
		cfg_data  <= ivl;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		cur_timeout  = tmo;
		cur_interval = ivl;
	endtask

	// result side: random stalls, long ones now and then, none in quiet phases
	always @(posedge clk) begin
		int r;
		if (no_idle) begin
			stall_left = 0;
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 29);
				rsp_ch.ready <= 1'b0;
			end
		end
	end

	// scoreboard: each accepted result against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: kind %0d slot %0d id %h",
					rsp_ch.kind, rsp_ch.slot, rsp_ch.out_id);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
					mismatch_count++;
				end
				if (rsp_ch.slot !== want.slot) begin
					$error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
					mismatch_count++;
				end
				if (rsp_ch.out_id !== want.out_id) begin
					$error("out_id: expected %h, actual %h", want.out_id, rsp_ch.out_id);
					mismatch_count++;
				end
				if (rsp_ch.out_nick !== want.out_nick) begin
					$error("out_nick: expected %h, actual %h", want.out_nick, rsp_ch.out_nick);
					mismatch_count++;
				end
				if (rsp_ch.out_room !== want.out_room) begin
					$error("out_room: expected %0d, actual %0d", want.out_room, rsp_ch.out_room);
					mismatch_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	// safety net far beyond the slowest legal run
	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] phase_tmo [PHASES];
		logic [CFG_W-1:0] phase_ivl [PHASES];
		bit               phase_quiet [PHASES];
		stim_row_t        row;
		int               r;

		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= CFG_TIMEOUT;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_NONE;
		req_ch.peer_id   <= '0;
		req_ch.peer_nick <= '0;
		req_ch.peer_room <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset values of both registers
		// empty table: any lookup misses
		add_row(OP_LOOKUP, '0, '1, 8'hFF, 1'b1, 1,
			mk_rsp(KIND_MISS, '0, '0, '0, '0, 1'b1));
		// first tick: no sweep due yet
		add_row(OP_TICK, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 1'b1, 1,
			mk_rsp(KIND_TICK_DONE, '0, '0, '0, '0, 1'b1));
		// all-ones and all-zero peers fill the first two slots
		add_row(OP_ANNOUNCE, '1, '1, 8'hFF, 1'b1, 1,
			mk_rsp(KIND_INSERTED, 4'd0, '1, '1, 8'hFF, 1'b1));
		add_row(OP_ANNOUNCE, '0, '0, 8'h00, 1'b1, 1,
			mk_rsp(KIND_INSERTED, 4'd1, '0, '0, 8'h00, 1'b1));
		add_row(OP_LOOKUP, '1, '0, 8'h00, 1'b1, 1,
			mk_rsp(KIND_FOUND, 4'd0, '1, '1, 8'hFF, 1'b1));
		// refresh with a zero first byte: stored nickname becomes empty
		add_row(OP_ANNOUNCE, '1, 64'hFFFF_FFFF_FFFF_FF00, 8'h5A, 1'b1, 1,
			mk_rsp(KIND_UPDATED, 4'd0, '1, '0, 8'h5A, 1'b1));
		// zero byte in the middle: everything above it is cleared
		add_row(OP_ANNOUNCE, 64'h0123_4567_89AB_CDEF, 64'h4142_0043_4445_4647, 8'h80, 1'b1, 1,
			mk_rsp(KIND_INSERTED, 4'd2, 64'h0123_4567_89AB_CDEF, 64'h0000_0043_4445_4647,
				8'h80, 1'b1));
		// unused op code: no result at all
		add_row(OP_NONE, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 1'b1, 0);
		add_row(OP_LOOKUP, '0, '1, 8'hFF, 1'b1, 1,
			mk_rsp(KIND_FOUND, 4'd1, '0, '0, 8'h00, 1'b1));
		add_row(OP_LOOKUP, {$urandom, $urandom}, random_nick(), 8'($urandom));
		// fill the rest of the table
		for (int i = 3; i < DEPTH; i++) begin
			add_row(OP_ANNOUNCE, {$urandom, $urandom}, random_nick(), 8'($urandom));
		end
		// full table: the new peer is dropped and echoed
		add_row(OP_ANNOUNCE, 64'hA5A5_A5A5_5A5A_5A5A, 64'h0102_0304_0506_0708, 8'h7F, 1'b1, 1,
			mk_rsp(KIND_DROPPED, '0, 64'hA5A5_A5A5_5A5A_5A5A, 64'h0102_0304_0506_0708,
				8'h7F, 1'b1));
		add_row(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, 8'h00);
		foreach (directed_rows[i]) send_item(directed_rows[i]);
		drain();

		// register settings per phase: zero, one and the top value among them
		phase_tmo   = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(1, 12)),
			16'd2, 16'($urandom_range(1, 40)), 16'hFFFF};
		phase_ivl   = '{16'd0, 16'd1, 16'hFFFF, 16'd4, 16'($urandom_range(0, 6)),
			16'd0, 16'($urandom_range(0, 20)), 16'd0};
		phase_quiet = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

		for (int p = 0; p < PHASES; p++) begin
			write_config(phase_tmo[p], phase_ivl[p]);
			no_idle = phase_quiet[p];
			repeat (PHASE_ITEMS) begin
				row.typed   = 1'b0;
				row.n_typed = 0;
				row.want    = '0;
				row.id      = {$urandom, $urandom};
				row.nick    = random_nick();
				row.room    = 8'($urandom);
				r = $urandom_range(0, 99);
				if (r < 40) begin
					// mostly refreshes of known peers, the rest strangers that get dropped
					row.op = OP_ANNOUNCE;
					if ($urandom_range(0, 99) < 65 && tbl_used > 0)
						row.id = tbl_id[$urandom_range(0, tbl_used - 1)];
				end else if (r < 75) begin
					row.op = OP_TICK;
				end else if (r < 97) begin
					row.op = OP_LOOKUP;
					if ($urandom_range(0, 99) < 70 && tbl_used > 0)
						row.id = tbl_id[$urandom_range(0, tbl_used - 1)];
				end else begin
					row.op = OP_NONE;
				end
				send_item(row);
			end
			// sender holds off until every result of the phase has come back
			drain();
		end
		no_idle = 1'b0;

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
